### design/pcs_pkg.sv
package pcs_pkg;

	// width of the corner point count register
	localparam int CFG_W = 6;

	// corner point count after reset
	localparam logic [CFG_W-1:0] PPC_RESET = 6'd8;

	// request to the shared divider
	typedef struct packed {
		logic start;
		logic neg;
	} div_req_t;

endpackage

### design/polyline_corner_smoother.sv
// channel | direction | handshake          | word
// cfg     | in        | cfg_valid/cfg_ready | cfg_data (points per corner)
// in      | in        | in_valid/in_stall   | point_x, point_y, end_of_path
// out     | out       | out_valid/out_stall | out_x, out_y, last_point
//
// one waypoint at a time; in_stall is high from acceptance until its last word, if any,
// is handed to the output register.
// a corner yields R curve points, plus the final point when it ends the path:
// each curve point needs two serial divisions, one quotient bit per cycle.
// arst_n clears the sequencer, the path state and out_valid, and sets the configuration register (R = 8).
// out_stall only holds the output register; the sequencer waits for it.
module polyline_corner_smoother #(
	parameter int MAX_CORNER_POINTS = 32,
	parameter int COORD_WIDTH       = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pcs_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic                          end_of_path,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_WIDTH-1:0] out_x,
	output logic signed [COORD_WIDTH-1:0] out_y,
	output logic                          last_point
);
	import pcs_pkg::*;

	localparam int W  = COORD_WIDTH;
	localparam int RW = $clog2(MAX_CORNER_POINTS + 1);
	localparam int SW = 2 * RW;
	localparam int NW = W + SW + 2;
	localparam int MW = W + SW;
	localparam int DW = SW + 1;

	typedef enum logic [9:0] {
		ST_IDLE       = 10'b0000000001,
		ST_DECODE     = 10'b0000000010,
		ST_EMIT_IN    = 10'b0000000100,
		ST_WEIGHTS    = 10'b0000001000,
		ST_MAC_A      = 10'b0000010000,
		ST_MAC_M      = 10'b0000100000,
		ST_MAC_B      = 10'b0001000000,
		ST_DIV_GO     = 10'b0010000000,
		ST_DIV_WAIT   = 10'b0100000000,
		ST_EMIT_CURVE = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0]    ppc_q;
	logic [1:0]          seen_q;
	logic signed [W-1:0] older_x_q, older_y_q, vertex_x_q, vertex_y_q;
	logic signed [W-1:0] px_q, py_q;
	logic                last_q;
	logic [RW-1:0]       r_q, i_q;
	logic [DW-1:0]       den_q;
	logic                sel_y_q;
	logic signed [W:0]   ax_q, ay_q, bx_q, by_q;
	logic [SW-1:0]       wa2_q, wia4_q, wi2_q;
	logic signed [NW-1:0] acc_q;
	logic signed [W-1:0] qx_q;
	logic signed [W-1:0] out_x_q, out_y_q;
	logic                out_last_q;
	logic                out_valid_q;

	logic                out_free;
	logic                out_load;
	logic [RW-1:0]       r_clamp;
	logic [SW-1:0]       rsq;
	logic [RW-1:0]       a_w;
	logic [SW-1:0]       wa2, ia, wi2;
	logic signed [W:0]   op_a;
	logic [SW-1:0]       op_b;
	logic signed [NW-1:0] prod;
	logic [NW-1:0]       acc_neg;
	logic [MW-1:0]       mag;
	div_req_t            div_req;
	logic                div_done;
	logic signed [W-1:0] div_quo;

	// handshakes
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_load  = out_free && ((state_q == ST_EMIT_IN) || (state_q == ST_EMIT_CURVE));
	assign out_valid  = out_valid_q;
	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign last_point = out_last_q;

	// clamp the corner point count and form the divisor 2*r*r
	always_comb begin
		if (ppc_q == '0) begin
			r_clamp = RW'(1);
		end else if (ppc_q > CFG_W'(MAX_CORNER_POINTS)) begin
			r_clamp = RW'(MAX_CORNER_POINTS);
		end else begin
			r_clamp = RW'(ppc_q);
		end
	end
	assign rsq = SW'(r_clamp) * SW'(r_clamp);

	// bernstein weights for step i, scaled by r*r
	assign a_w = r_q - i_q;
	assign wa2 = SW'(a_w) * SW'(a_w);
	assign ia  = SW'(i_q) * SW'(a_w);
	assign wi2 = SW'(i_q) * SW'(i_q);

	// shared multiply-accumulate operand select
	always_comb begin
		case (state_q)
			ST_MAC_A: begin
				op_a = sel_y_q ? ay_q : ax_q;
				op_b = wa2_q;
			end
			ST_MAC_M: begin
				op_a = sel_y_q ? {vertex_y_q[W-1], vertex_y_q} : {vertex_x_q[W-1], vertex_x_q};
				op_b = wia4_q;
			end
			ST_MAC_B: begin
				op_a = sel_y_q ? by_q : bx_q;
				op_b = wi2_q;
			end
			default: begin
				op_a = ax_q;
				op_b = wa2_q;
			end
		endcase
	end
	assign prod = NW'(op_a) * NW'($signed({1'b0, op_b}));

	// magnitude and sign toward the divider
	assign acc_neg     = -acc_q;
	assign mag         = acc_q[NW-1] ? acc_neg[MW-1:0] : acc_q[MW-1:0];
	assign div_req.start = (state_q == ST_DIV_GO);
	assign div_req.neg   = acc_q[NW-1];

	pcs_div #(
		.MAG_W (MW),
		.QUO_W (W),
		.DEN_W (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.mag    (mag),
		.den    (den_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppc_q <= PPC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ppc_q <= cfg_data;
		end
	end

	// output word valid: set on load, cleared once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// sequencer and path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			seen_q      <= 2'd0;
			older_x_q   <= '0;
			older_y_q   <= '0;
			vertex_x_q  <= '0;
			vertex_y_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					case (seen_q)
						2'd0: begin
							state_q <= ST_EMIT_IN;
							if (!last_q) begin
								vertex_x_q <= px_q;
								vertex_y_q <= py_q;
								seen_q     <= 2'd1;
							end
						end
						2'd1: begin
							if (last_q) begin
								seen_q  <= 2'd0;
								state_q <= ST_EMIT_IN;
							end else begin
								older_x_q  <= vertex_x_q;
								older_y_q  <= vertex_y_q;
								vertex_x_q <= px_q;
								vertex_y_q <= py_q;
								seen_q     <= 2'd2;
								state_q    <= ST_IDLE;
							end
						end
						2'd2: begin
							state_q <= ST_WEIGHTS;
						end
						default: begin
							seen_q  <= 2'd0;
							state_q <= ST_IDLE;
						end
					endcase
				end
				ST_EMIT_IN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WEIGHTS:  state_q <= ST_MAC_A;
				ST_MAC_A:    state_q <= ST_MAC_M;
				ST_MAC_M:    state_q <= ST_MAC_B;
				ST_MAC_B:    state_q <= ST_DIV_GO;
				ST_DIV_GO:   state_q <= ST_DIV_WAIT;
				ST_DIV_WAIT: begin
					if (div_done) begin
						state_q <= sel_y_q ? ST_EMIT_CURVE : ST_MAC_A;
					end
				end
				ST_EMIT_CURVE: begin
					if (out_free) begin
						if (i_q == r_q - RW'(1)) begin
							if (last_q) begin
								seen_q  <= 2'd0;
								state_q <= ST_EMIT_IN;
							end else begin
								older_x_q  <= vertex_x_q;
								older_y_q  <= vertex_y_q;
								vertex_x_q <= px_q;
								vertex_y_q <= py_q;
								state_q    <= ST_IDLE;
							end
						end else begin
							state_q <= ST_WEIGHTS;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers of the shared datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				px_q   <= point_x;
				py_q   <= point_y;
				last_q <= end_of_path;
			end
			ST_DECODE: begin
				r_q     <= r_clamp;
				den_q   <= {rsq, 1'b0};
				i_q     <= '0;
				sel_y_q <= 1'b0;
				ax_q    <= {older_x_q[W-1], older_x_q} + {vertex_x_q[W-1], vertex_x_q};
				ay_q    <= {older_y_q[W-1], older_y_q} + {vertex_y_q[W-1], vertex_y_q};
				bx_q    <= {vertex_x_q[W-1], vertex_x_q} + {px_q[W-1], px_q};
				by_q    <= {vertex_y_q[W-1], vertex_y_q} + {py_q[W-1], py_q};
			end
			ST_EMIT_IN: begin
				if (out_free) begin
					out_x_q    <= px_q;
					out_y_q    <= py_q;
					out_last_q <= last_q;
				end
			end
			ST_WEIGHTS: begin
				wa2_q  <= wa2;
				wia4_q <= SW'({ia, 2'b00});
				wi2_q  <= wi2;
			end
			ST_MAC_A: acc_q <= prod;
			ST_MAC_M: acc_q <= acc_q + prod;
			ST_MAC_B: acc_q <= acc_q + prod;
			ST_DIV_WAIT: begin
				if (div_done && !sel_y_q) begin
					qx_q    <= div_quo;
					sel_y_q <= 1'b1;
				end
			end
			ST_EMIT_CURVE: begin
				if (out_free) begin
					out_x_q    <= qx_q;
					out_y_q    <= div_quo;
					out_last_q <= 1'b0;
					i_q        <= i_q + RW'(1);
					sel_y_q    <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### design/pcs_div.sv
module pcs_div #(
	parameter int MAG_W = 36,
	parameter int QUO_W = 24,
	parameter int DEN_W = 13
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pcs_pkg::div_req_t       req,
	input  logic [MAG_W-1:0]        mag,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic signed [QUO_W-1:0] quo
);
	import pcs_pkg::*;

	localparam int CW = $clog2(QUO_W);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [QUO_W-1:0] sr_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             neg_q;

	logic [DEN_W:0]   rem_sh;
	logic [DEN_W:0]   diff;
	logic             fits;
	logic [DEN_W-1:0] rem_nx;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_sh = {rem_q, sr_q[QUO_W-1]};
	assign diff   = rem_sh - {1'b0, den_q};
	assign fits   = rem_sh >= {1'b0, den_q};
	assign rem_nx = fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];

	// quotient bits collect in the dividend shift register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CW'(1);
			if (cnt_q == CW'(QUO_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= DEN_W'(mag[MAG_W-1:QUO_W]);
			sr_q  <= mag[QUO_W-1:0];
			den_q <= den;
			neg_q <= req.neg;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			sr_q  <= {sr_q[QUO_W-2:0], fits};
		end
	end

	// restore the sign, truncation toward zero
	assign done = done_q;
	assign quo  = neg_q ? $signed(-sr_q) : $signed(sr_q);

endmodule

### design/pcs_checker.sv
module pcs_checker #(
	parameter int COORD_WIDTH = 24
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [COORD_WIDTH-1:0] out_x,
	input logic signed [COORD_WIDTH-1:0] out_y,
	input logic                          last_point
);

	// a stalled output word stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output word dropped while stalled");

	// a stalled output word keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(last_point))
		else $error("output word changed while stalled");

	// in the cycle after a waypoint is accepted, in_stall is always high
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after a waypoint");

	// a new output word only comes from work on an accepted waypoint
	a_word_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("output word appeared while idle");

endmodule

bind polyline_corner_smoother pcs_checker #(.COORD_WIDTH(COORD_WIDTH)) u_pcs_checker (.*);
